@@ sv/rbsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types for the ray/box slab intersection block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // fixed point format and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int SIZE_W    = 31;
  localparam int Q_W       = 32;
  localparam int DIFF_W    = 35;
  localparam int NUM_W     = DIFF_W + FRAC_BITS;
  localparam int DEN_W     = 33;
  localparam int T_W       = 31;
  localparam int AXES      = 3;

  localparam logic signed [Q_W-1:0] TMAX = {1'b0, {(Q_W-1){1'b1}}};

  // what one axis lane reports to the merge stage
  typedef struct packed {
    logic                  par;
    logic                  par_miss;
    logic signed [Q_W-1:0] t_lo;
    logic signed [Q_W-1:0] t_hi;
  } lane_res_t;

endpackage

@@ sv/rbsi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module rbsi_div
  import rbsi_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  logic [DEN_W-1:0] rem_s [0:Q_W];
  logic [Q_W-1:0]   low_s [0:Q_W];
  logic [Q_W-1:0]   quo_s [0:Q_W];
  logic [DEN_W-1:0] den_s [0:Q_W];
  logic             ovf_s [0:Q_W];

  // first partial remainder is the dividend above the quotient bits
  assign rem_s[0] = DEN_W'(num[NUM_W-1:Q_W]);
  assign low_s[0] = num[Q_W-1:0];
  assign quo_s[0] = '0;
  assign den_s[0] = den;
  assign ovf_s[0] = (DEN_W'(num[NUM_W-1:Q_W]) >= den);

  // one trial subtract per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_s[i], low_s[i][Q_W-1]};
    assign ge    = (trial >= {1'b0, den_s[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, den_s[i]}) : trial[DEN_W-1:0];
        low_s[i+1] <= {low_s[i][Q_W-2:0], 1'b0};
        quo_s[i+1] <= {quo_s[i][Q_W-2:0], ge};
        den_s[i+1] <= den_s[i];
        ovf_s[i+1] <= ovf_s[i];
      end
    end
  end

  assign quo = quo_s[Q_W];
  assign ovf = ovf_s[Q_W];

endmodule

@@ sv/rbsi_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis of the slab test: bounds, parallel check, two slab distances
// through pipelined dividers, clamped to [-1, TMAX] and ordered.
// ----------------------------------------------------------------------------
module rbsi_lane
  import rbsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CRD_W-1:0]  origin,
  input  logic signed [CRD_W-1:0]  dir,
  input  logic signed [CRD_W-1:0]  center,
  input  logic        [SIZE_W-1:0] size,
  output lane_res_t                res
);

  logic signed [DIFF_W-1:0] o2, c2, sz, lo2, hi2, d_lo, d_hi;
  logic        [DIFF_W-1:0] m_lo, m_hi;
  logic        [DEN_W-1:0]  den;
  logic                     dneg;

  // doubled bounds and distances to the origin
  always_comb begin
    o2   = DIFF_W'(origin) <<< 1;
    c2   = DIFF_W'(center) <<< 1;
    sz   = DIFF_W'({1'b0, size});
    lo2  = c2 - sz;
    hi2  = c2 + sz;
    d_lo = lo2 - o2;
    d_hi = hi2 - o2;
    m_lo = d_lo[DIFF_W-1] ? DIFF_W'(-d_lo) : DIFF_W'(d_lo);
    m_hi = d_hi[DIFF_W-1] ? DIFF_W'(-d_hi) : DIFF_W'(d_hi);
    dneg = dir[CRD_W-1];
    den  = dneg ? {DEN_W'(-DEN_W'(dir))} << 1 : DEN_W'({1'b0, dir}) << 1;
  end

  // input register
  logic [NUM_W-1:0] num_lo, num_hi;
  logic [DEN_W-1:0] den_r;
  logic             par_s  [0:Q_W];
  logic             miss_s [0:Q_W];
  logic             nlo_s  [0:Q_W];
  logic             nhi_s  [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      num_lo    <= {m_lo, {FRAC_BITS{1'b0}}};
      num_hi    <= {m_hi, {FRAC_BITS{1'b0}}};
      den_r     <= den;
      par_s[0]  <= (dir == '0);
      miss_s[0] <= (o2 < lo2) || (o2 > hi2);
      nlo_s[0]  <= d_lo[DIFF_W-1] ^ dneg;
      nhi_s[0]  <= d_hi[DIFF_W-1] ^ dneg;
    end
  end

  // sideband follows the divider stages
  for (genvar k = 0; k < Q_W; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (en) begin
        par_s[k+1]  <= par_s[k];
        miss_s[k+1] <= miss_s[k];
        nlo_s[k+1]  <= nlo_s[k];
        nhi_s[k+1]  <= nhi_s[k];
      end
    end
  end

  logic [Q_W-1:0] q_lo, q_hi;
  logic           ovf_lo, ovf_hi;

  rbsi_div u_div_lo (
    .clk(clk), .en(en), .num(num_lo), .den(den_r), .quo(q_lo), .ovf(ovf_lo)
  );
  rbsi_div u_div_hi (
    .clk(clk), .en(en), .num(num_hi), .den(den_r), .quo(q_hi), .ovf(ovf_hi)
  );

  // clamp: a negative distance reads as -1 (or 0 if its magnitude truncates to zero), large ones as TMAX
  function automatic logic signed [Q_W-1:0] clamp_t(
    input logic [Q_W-1:0] q, input logic ov, input logic neg);
    logic signed [Q_W-1:0] t;
    begin
      if (neg) t = (ov || (q != '0)) ? '1 : '0;
      else if (ov || q[Q_W-1]) t = TMAX;
      else t = q;
      return t;
    end
  endfunction

  logic signed [Q_W-1:0] t1, t2;

  // order the two slab distances
  always_comb begin
    t1           = clamp_t(q_lo, ovf_lo, nlo_s[Q_W]);
    t2           = clamp_t(q_hi, ovf_hi, nhi_s[Q_W]);
    res.par      = par_s[Q_W];
    res.par_miss = miss_s[Q_W];
    res.t_lo     = (t1 > t2) ? t2 : t1;
    res.t_hi     = (t1 > t2) ? t1 : t2;
  end

endmodule

@@ sv/rbsi_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_merge
// Folds the three lane intervals into entry/exit and holds the output item.
// ----------------------------------------------------------------------------
module rbsi_merge
  import rbsi_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  lane_res_t        lane [AXES],
  output logic             hit,
  output logic [T_W-1:0]   t_entry,
  output logic [T_W-1:0]   t_exit
);

  logic signed [Q_W-1:0] tmin, tmax;
  logic                  h;

  // interval fold over the axes
  always_comb begin
    tmin = '0;
    tmax = TMAX;
    h    = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if (lane[a].par) begin
        if (lane[a].par_miss) h = 1'b0;
      end else begin
        if (lane[a].t_lo > tmin) tmin = lane[a].t_lo;
        if (lane[a].t_hi < tmax) tmax = lane[a].t_hi;
        if (tmin > tmax) h = 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      hit     <= h;
      t_entry <= h ? tmin[T_W-1:0] : '0;
      t_exit  <= h ? tmax[T_W-1:0] : '0;
    end
  end

endmodule

@@ sv/ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box slab test, one lane per axis plus a merge.
// ----------------------------------------------------------------------------
// pipeline: input register, 32 divider stages and output register lie between
//   input accept and the first edge at which the result can be taken
// throughput: one item per cycle; the whole pipeline holds while a result
//   waits on out_ready
// reset: rst clears the stage valid bits and out_valid; data needs none
module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [CRD_W-1:0]  origin_x,
  input  logic signed [CRD_W-1:0]  origin_y,
  input  logic signed [CRD_W-1:0]  origin_z,
  input  logic signed [CRD_W-1:0]  dir_x,
  input  logic signed [CRD_W-1:0]  dir_y,
  input  logic signed [CRD_W-1:0]  dir_z,
  input  logic signed [CRD_W-1:0]  box_center_x,
  input  logic signed [CRD_W-1:0]  box_center_y,
  input  logic signed [CRD_W-1:0]  box_center_z,
  input  logic        [SIZE_W-1:0] box_size_x,
  input  logic        [SIZE_W-1:0] box_size_y,
  input  logic        [SIZE_W-1:0] box_size_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic        [T_W-1:0]    t_entry,
  output logic        [T_W-1:0]    t_exit
);

  logic      en;
  logic      vld [0:Q_W];
  lane_res_t lane [AXES];

  // advance when the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // axis lanes
  rbsi_lane u_lane_x (
    .clk(clk), .en(en), .origin(origin_x), .dir(dir_x),
    .center(box_center_x), .size(box_size_x), .res(lane[0])
  );
  rbsi_lane u_lane_y (
    .clk(clk), .en(en), .origin(origin_y), .dir(dir_y),
    .center(box_center_y), .size(box_size_y), .res(lane[1])
  );
  rbsi_lane u_lane_z (
    .clk(clk), .en(en), .origin(origin_z), .dir(dir_z),
    .center(box_center_z), .size(box_size_z), .res(lane[2])
  );

  rbsi_merge u_merge (
    .clk(clk), .en(en), .lane(lane), .hit(hit), .t_entry(t_entry), .t_exit(t_exit)
  );

  // item valid chain alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Q_W; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= Q_W; k++) vld[k] <= vld[k-1];
      out_valid <= vld[Q_W];
    end
  end

  // a miss reports zero distances
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> t_entry == '0 && t_exit == '0)
    else $error("miss with nonzero distances");

  // a hit interval is ordered
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> t_entry <= t_exit)
    else $error("entry beyond exit");

  // a held result stops intake
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

@@ bench/tb_ray_box_slab_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// Stream bench for the ray/box slab test: directed corner rays, then random
// rays in several idle/stall phases, each result checked against a predictor.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] org [3];
    logic signed [CRD_W-1:0] dir [3];
    logic signed [CRD_W-1:0] ctr [3];
    logic [SIZE_W-1:0]       sz  [3];
  } ray_item_t;

  typedef struct {
    logic           hit;
    logic [T_W-1:0] t_in;
    logic [T_W-1:0] t_out;
  } hit_res_t;

  int n_errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // slab distance, exact in 64 bits, truncated toward zero, clipped above
  function automatic longint slab_t(longint b2, longint o2, longint d2);
    longint q;
    q = ((b2 - o2) * (64'sd1 <<< FRAC_BITS)) / d2;
    if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
    return q;
  endfunction

  function automatic hit_res_t predict_hit(ray_item_t it);
    hit_res_t r;
    longint tmn, tmx, o2, d, lo2, hi2, t1, t2, s;
    bit h;
    tmn = 0; tmx = 64'sh7FFFFFFF; h = 1;
    for (int a = 0; a < 3; a++) begin
      o2 = 2 * longint'(it.org[a]);
      d = longint'(it.dir[a]);
      lo2 = 2 * longint'(it.ctr[a]) - longint'({1'b0, it.sz[a]});
      hi2 = 2 * longint'(it.ctr[a]) + longint'({1'b0, it.sz[a]});
      if (d == 0) begin
        if (o2 < lo2 || o2 > hi2) h = 0;
      end else begin
        t1 = slab_t(lo2, o2, 2 * d);
        t2 = slab_t(hi2, o2, 2 * d);
        if (t1 > t2) begin
          s = t1; t1 = t2; t2 = s;
        end
        if (t1 > tmn) tmn = t1;
        if (t2 < tmx) tmx = t2;
        if (tmn > tmx) h = 0;
      end
    end
    r.hit = h;
    r.t_in = h ? tmn[T_W-1:0] : '0;
    r.t_out = h ? tmx[T_W-1:0] : '0;
    return r;
  endfunction

  class hit_scoreboard;
    hit_res_t pending[$];
    int n_checked = 0;
    int n_hits = 0;

    function void note_ray(ray_item_t it);
      pending.push_back(predict_hit(it));
    endfunction

    task check_result(logic h, logic [T_W-1:0] ti, logic [T_W-1:0] to);
      hit_res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", h, 0);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.hit) n_hits++;
      if (h !== e.hit) report("hit", h, e.hit);
      if (ti !== e.t_in) report("t_entry", ti, e.t_in);
      if (to !== e.t_out) report("t_exit", to, e.t_out);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, hit;
  logic signed [CRD_W-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [CRD_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic signed [CRD_W-1:0] box_center_x = 0, box_center_y = 0, box_center_z = 0;
  logic [SIZE_W-1:0] box_size_x = 0, box_size_y = 0, box_size_z = 0;
  logic [T_W-1:0] t_entry, t_exit;

  int send_idle_pct = 0, recv_stall_pct = 0;
  hit_scoreboard sb = new();

  ray_box_slab_intersect i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("ray_box_slab_intersect test failed");
    $finish;
  end

  // result side: stall at random, check each accepted item
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(hit, t_entry, t_exit);
  end
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high across back-to-back items; it drops only while idling or draining
  task automatic send_ray(ray_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    origin_x <= it.org[0]; origin_y <= it.org[1]; origin_z <= it.org[2];
    dir_x <= it.dir[0]; dir_y <= it.dir[1]; dir_z <= it.dir[2];
    box_center_x <= it.ctr[0]; box_center_y <= it.ctr[1]; box_center_z <= it.ctr[2];
    box_size_x <= it.sz[0]; box_size_y <= it.sz[1]; box_size_z <= it.sz[2];
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_ray(it);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic ray_item_t rand_ray();
    ray_item_t it;
    logic [31:0] cube;
    cube = $urandom_range(1, 40 << 16);
    for (int a = 0; a < 3; a++) begin
      it.org[a] = rand_coord();
      it.ctr[a] = rand_coord();
      case ($urandom_range(7))
        0: it.dir[a] = 0;
        1: it.dir[a] = $urandom();
        default: it.dir[a] = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      endcase
      case ($urandom_range(4))
        0: it.sz[a] = SIZE_W'($urandom());
        1: it.sz[a] = cube[SIZE_W-1:0];
        2: it.sz[a] = $urandom_range(1) ? '1 : '0;
        default: it.sz[a] = SIZE_W'($urandom_range(0, 60 << 16));
      endcase
    end
    return it;
  endfunction

  // ray aimed at the box center, so most items hit
  function automatic ray_item_t aimed_ray();
    ray_item_t it;
    it = rand_ray();
    for (int a = 0; a < 3; a++) begin
      it.ctr[a] = 32'($signed($urandom_range(0, 100 << 16)) - (50 << 16));
      it.org[a] = 32'($signed($urandom_range(0, 100 << 16)) - (50 << 16));
      it.dir[a] = 32'((it.ctr[a] - it.org[a]) >>> $urandom_range(0, 6));
      it.sz[a] = SIZE_W'($urandom_range(1 << 16, 20 << 16));
    end
    return it;
  endfunction

  function automatic ray_item_t make_ray(logic [31:0] o, logic [31:0] d,
                                         logic [31:0] c, logic [SIZE_W-1:0] s);
    ray_item_t it;
    for (int a = 0; a < 3; a++) begin
      it.org[a] = o; it.dir[a] = d; it.ctr[a] = c; it.sz[a] = s;
    end
    return it;
  endfunction

  // sender goes quiet until every expected result has come
  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    ray_item_t it;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed corners: parallel inside/outside, faces, far box, extremes
    send_ray(make_ray(0, 0, 0, 2 << 16));
    send_ray(make_ray(5 << 16, 0, 0, 2 << 16));
    send_ray(make_ray(1 << 16, 0, 0, 2 << 16));
    send_ray(make_ray(-(5 << 16), 1 << 16, 0, 2 << 16));
    send_ray(make_ray(5 << 16, 1 << 16, 0, 2 << 16));
    send_ray(make_ray(-(5 << 16), 1 << 16, 0, 0));
    send_ray(make_ray(32'h80000000, 1, 32'h7FFFFFFF, '1));
    send_ray(make_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    send_ray(make_ray(32'h7FFFFFFF, 32'h80000000, 32'h80000000, '1));
    send_ray(make_ray(32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, '1));
    send_ray(make_ray(32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 1));
    send_ray(make_ray(-(3 << 16), 1 << 16, 0, 2 << 16));
    it = make_ray(0, 1 << 16, 10 << 16, 2 << 16);
    it.dir[1] = -(1 << 16); it.dir[2] = 0; it.org[2] = 10 << 16;
    send_ray(it);
    it = make_ray(0, 1 << 16, 0, 2 << 16);
    it.org[1] = 32'hAAAAAAAA; it.dir[2] = 32'h55555555;
    send_ray(it);
    wait_drained();

    // random phases: free, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 19 : 78) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 19 : 78) : 0;
      for (int i = 0; i < 400; i++) begin
        send_ray($urandom_range(2) == 0 ? rand_ray() : aimed_ray());
        if (i == 200) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("covered %0d results, %0d hits, over four idle/stall phases",
             sb.n_checked, sb.n_hits);
    if (n_errors == 0 && sb.pending.size() == 0) begin
      $display("ray_box_slab_intersect test passed");
    end else begin
      $display("ray_box_slab_intersect test failed");
    end
    $finish;
  end
endmodule
